// ===== rtl/agmm_pkg.sv =====
// Shared types, codes and the sequencer microprogram for the gain mixer.
package agmm_pkg;

    localparam int SAMPLE_W = 16;
    localparam int PROD_W   = 32;
    localparam int ACC_W    = 40;
    localparam int STEP_W   = 3;

    // Request codes
    localparam logic [1:0] REQ_SAMPLE = 2'd0;
    localparam logic [1:0] REQ_FADER  = 2'd1;
    localparam logic [1:0] REQ_MATRIX = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_MODE     = 2'd0;
    localparam logic [1:0] CFG_CHANNELS = 2'd1;
    localparam logic [1:0] CFG_ACTIVE   = 2'd2;

    typedef logic [STEP_W-1:0] t_step;

    localparam t_step STEP_WAIT   = 3'd0;
    localparam t_step STEP_DECODE = 3'd1;
    localparam t_step STEP_MUL    = 3'd2;
    localparam t_step STEP_ACC    = 3'd3;
    localparam t_step STEP_FRAME  = 3'd4;
    localparam t_step STEP_EMIT   = 3'd5;
    localparam t_step STEP_CLEAR  = 3'd6;
    localparam t_step STEP_SPARE  = 3'd7;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_WAIT,
        OP_DECODE,
        OP_MUL,
        OP_ACC,
        OP_FRAME,
        OP_EMIT,
        OP_CLEAR
    } t_op;

    typedef enum logic [2:0] {
        CND_NEVER,
        CND_ALWAYS,
        CND_NO_ACCEPT,
        CND_NO_MAC,
        CND_MORE_MAC,
        CND_NO_FRAME,
        CND_EMIT_HOLD
    } t_cond;

    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_step target;
    } t_uword;

    typedef struct packed {
        logic in_valid;
        logic no_mac;
        logic more_mac;
        logic frame_end;
        logic emit_hold;
    } t_flags;

    // Jump to target when the condition holds, else fall through to the next step.
    function automatic t_uword ucode(input t_step s);
        t_uword w;
        case (s)
            STEP_WAIT:   w = '{op: OP_WAIT,   cond: CND_NO_ACCEPT, target: STEP_WAIT};
            STEP_DECODE: w = '{op: OP_DECODE, cond: CND_NO_MAC,    target: STEP_FRAME};
            STEP_MUL:    w = '{op: OP_MUL,    cond: CND_NEVER,     target: STEP_WAIT};
            STEP_ACC:    w = '{op: OP_ACC,    cond: CND_MORE_MAC,  target: STEP_MUL};
            STEP_FRAME:  w = '{op: OP_FRAME,  cond: CND_NO_FRAME,  target: STEP_WAIT};
            STEP_EMIT:   w = '{op: OP_EMIT,   cond: CND_EMIT_HOLD, target: STEP_EMIT};
            STEP_CLEAR:  w = '{op: OP_CLEAR,  cond: CND_ALWAYS,    target: STEP_WAIT};
            default:     w = '{op: OP_NOP,    cond: CND_ALWAYS,    target: STEP_WAIT};
        endcase
        return w;
    endfunction

endpackage

// ===== rtl/agmm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module agmm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic                                  i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/agmm_seq.sv =====
// Microcode sequencer: step counter, control store and conditional jumps.
module agmm_seq
    import agmm_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_flags i_flags,
    output t_uword o_uword
);

    t_step  r_step;
    t_step  n_step;
    t_uword uw;
    logic   jump;

    assign uw = ucode(r_step);

    always_comb begin
        case (uw.cond)
            CND_NEVER:     jump = 1'b0;
            CND_ALWAYS:    jump = 1'b1;
            CND_NO_ACCEPT: jump = !i_flags.in_valid;
            CND_NO_MAC:    jump = i_flags.no_mac;
            CND_MORE_MAC:  jump = i_flags.more_mac;
            CND_NO_FRAME:  jump = !i_flags.frame_end;
            CND_EMIT_HOLD: jump = i_flags.emit_hold;
            default:       jump = 1'b1;
        endcase
        n_step = jump ? uw.target : r_step + t_step'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= STEP_WAIT;
        end else begin
            r_step <= n_step;
        end
    end

    assign o_uword = uw;

endmodule

// ===== rtl/audio_gain_mixer_matrix.sv =====
// Audio gain mixer: microcoded multiply-accumulate over per-channel sums.
//
// Words arrive one at a time and are taken only while the sequencer waits for input. A gain
// write or a dropped sample runs the wait, decode and frame steps; a sample adds a multiply
// step and an accumulate step per channel, one channel in direct mode and every channel in
// use in matrix mode. A word with frame end set adds an emit step per channel, held while the
// output stalls, and a step that clears the sums. One shared 16x16 multiplier and one 40-bit
// saturating adder serve all channels. Matrix gains sit in a RAM read one entry per step; all
// gains and sums are zero after reset, with no clearing pass. The config port is always ready;
// the user must write it only while the mixer is idle, and the block itself does not enforce this.
module audio_gain_mixer_matrix
    import agmm_pkg::*;
#(
    parameter int MAX_INPUTS   = 8,
    parameter int MAX_CHANNELS = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_req_type,
    input  logic [2:0]         i_input_index,
    input  logic [2:0]         i_channel_index,
    input  logic signed [15:0] i_sample_value,
    input  logic signed [15:0] i_gain_value,
    input  logic               i_frame_end,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [2:0]         o_out_channel,
    output logic signed [15:0] o_out_sample,
    output logic               o_out_clipped,
    output logic               o_out_last,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [3:0]         i_cfg_data
);

    // Index fields are 3 bits wide, so no more than eight inputs or channels are reachable.
    localparam int NI    = (MAX_INPUTS < 8) ? MAX_INPUTS : 8;
    localparam int NC    = (MAX_CHANNELS < 8) ? MAX_CHANNELS : 8;
    localparam int MDEP  = NI * NC;
    localparam int AW    = (MDEP > 1) ? $clog2(MDEP) : 1;
    localparam int FIW   = (NI > 1) ? $clog2(NI) : 1;
    localparam int CIW   = (NC > 1) ? $clog2(NC) : 1;
    localparam logic [3:0] NI_LIM = 4'(NI);
    localparam logic [3:0] NC_LIM = 4'(NC);
    localparam logic [AW-1:0] NC_AW = AW'(NC);

    // Configuration
    logic       r_mode;
    logic [3:0] r_chan_cnt;
    logic [3:0] r_active;

    // Latched word
    logic [1:0]                r_req;
    logic [2:0]                r_inp;
    logic [2:0]                r_chn;
    logic signed [SAMPLE_W-1:0] r_sample;
    logic signed [SAMPLE_W-1:0] r_gain;
    logic                      r_fend;

    // Datapath
    logic signed [SAMPLE_W-1:0] r_fader [NI];
    logic [MDEP-1:0]           r_mvalid;
    logic                      r_mval_q;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [ACC_W-1:0]   r_sum [NC];
    logic [3:0]                r_c;

    // Output register
    logic                      r_out_valid;
    logic [2:0]                r_out_channel;
    logic signed [SAMPLE_W-1:0] r_out_sample;
    logic                      r_out_clipped;
    logic                      r_out_last;

    t_uword uw;
    t_flags flags;

    logic [3:0]                ch_used;
    logic [3:0]                c_inc;
    logic                      mac_ok;
    logic                      more_mac;
    logic                      out_free;
    logic                      fader_wr;
    logic                      matrix_wr;
    logic [AW-1:0]             waddr;
    logic [AW-1:0]             raddr;
    logic [3:0]                rd_c;
    logic                      rd_en;
    logic [SAMPLE_W-1:0]       ram_rdata;
    logic signed [SAMPLE_W-1:0] gain_sel;
    logic [CIW-1:0]            cidx;
    logic [FIW-1:0]            fidx;
    logic signed [ACC_W:0]     acc_wide;
    logic signed [ACC_W-1:0]   acc_sat;
    logic signed [ACC_W:0]     rnd;
    logic signed [ACC_W-12:0]  rnd_q;
    logic signed [SAMPLE_W-1:0] out_val;
    logic                      out_clip;

    agmm_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (flags),
        .o_uword (uw)
    );

    agmm_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (MDEP)
    ) u_matrix_ram (
        .i_clk   (i_clk),
        .i_we    (matrix_wr),
        .i_waddr (waddr),
        .i_wdata (r_gain),
        .i_re    (rd_en),
        .i_raddr (raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        if (r_chan_cnt == 4'd0) begin
            ch_used = 4'd1;
        end else if (r_chan_cnt > NC_LIM) begin
            ch_used = NC_LIM;
        end else begin
            ch_used = r_chan_cnt;
        end
    end

    assign c_inc = r_c + 4'd1;
    assign cidx  = r_c[CIW-1:0];
    assign fidx  = r_inp[FIW-1:0];

    always_comb begin
        mac_ok = 1'b0;
        if (r_req == REQ_SAMPLE) begin
            if (r_mode) begin
                mac_ok = (r_chn == 3'd0) && ({1'b0, r_inp} < r_active)
                         && ({1'b0, r_inp} < NI_LIM);
            end else begin
                mac_ok = ({1'b0, r_inp} < NI_LIM) && ({1'b0, r_chn} < ch_used);
            end
        end
    end

    assign more_mac  = r_mode && (c_inc < ch_used);
    assign out_free  = !r_out_valid || !i_out_stall;

    assign flags.in_valid  = i_in_valid;
    assign flags.no_mac    = !mac_ok;
    assign flags.more_mac  = more_mac;
    assign flags.frame_end = r_fend;
    assign flags.emit_hold = !out_free || (c_inc < ch_used);

    assign fader_wr  = (uw.op == OP_DECODE) && (r_req == REQ_FADER)
                       && ({1'b0, r_inp} < NI_LIM);
    assign matrix_wr = (uw.op == OP_DECODE) && (r_req == REQ_MATRIX)
                       && ({1'b0, r_inp} < NI_LIM) && ({1'b0, r_chn} < NC_LIM);
    assign waddr     = AW'(r_inp) * NC_AW + AW'(r_chn);

    // Fetch channel 0 while decoding, then the next channel on each accumulate with channels left.
    assign rd_c  = (uw.op == OP_DECODE) ? 4'd0 : c_inc;
    assign raddr = AW'(r_inp) * NC_AW + AW'(rd_c);
    assign rd_en = ((uw.op == OP_DECODE) && r_mode && mac_ok)
                   || ((uw.op == OP_ACC) && more_mac);

    assign gain_sel = r_mode ? (r_mval_q ? $signed(ram_rdata) : '0) : r_fader[fidx];

    // Saturating accumulate
    always_comb begin
        acc_wide = {r_sum[cidx][ACC_W-1], r_sum[cidx]}
                   + {{(ACC_W + 1 - PROD_W){r_prod[PROD_W-1]}}, r_prod};
        if (acc_wide[ACC_W] != acc_wide[ACC_W-1]) begin
            acc_sat = acc_wide[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        end else begin
            acc_sat = acc_wide[ACC_W-1:0];
        end
    end

    // Round half up to Q1.15, then saturate
    always_comb begin
        rnd      = {r_sum[cidx][ACC_W-1], r_sum[cidx]} + (ACC_W+1)'(2048);
        rnd_q    = rnd[ACC_W:12];
        out_clip = 1'b0;
        if (rnd_q > (ACC_W-11)'(32767)) begin
            out_val  = 16'sh7fff;
            out_clip = 1'b1;
        end else if (rnd_q < -(ACC_W-11)'(32768)) begin
            out_val  = 16'sh8000;
            out_clip = 1'b1;
        end else begin
            out_val = rnd_q[SAMPLE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_mval_q <= r_mvalid[raddr];
        end
        case (uw.op)
            OP_WAIT: begin
                if (i_in_valid) begin
                    r_req    <= i_req_type;
                    r_inp    <= i_input_index;
                    r_chn    <= i_channel_index;
                    r_sample <= i_sample_value;
                    r_gain   <= i_gain_value;
                    r_fend   <= i_frame_end;
                end
            end
            OP_MUL: begin
                r_prod <= PROD_W'(r_sample) * PROD_W'(gain_sel);
            end
            OP_EMIT: begin
                if (out_free) begin
                    r_out_channel <= r_c[2:0];
                    r_out_sample  <= out_val;
                    r_out_clipped <= out_clip;
                    r_out_last    <= (c_inc == ch_used);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= 1'b0;
            r_chan_cnt  <= 4'd2;
            r_active    <= 4'd8;
            r_mvalid    <= '0;
            r_c         <= 4'd0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < NI; i++) begin
                r_fader[i] <= '0;
            end
            for (int i = 0; i < NC; i++) begin
                r_sum[i] <= '0;
            end
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_MODE:     r_mode     <= i_cfg_data[0];
                    CFG_CHANNELS: r_chan_cnt <= i_cfg_data;
                    CFG_ACTIVE:   r_active   <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if ((uw.op == OP_EMIT) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (fader_wr) begin
                r_fader[fidx] <= r_gain;
            end
            if (matrix_wr) begin
                r_mvalid[waddr] <= 1'b1;
            end
            case (uw.op)
                OP_DECODE: begin
                    r_c <= r_mode ? 4'd0 : {1'b0, r_chn};
                end
                OP_ACC: begin
                    r_sum[cidx] <= acc_sat;
                    r_c         <= c_inc;
                end
                OP_FRAME: begin
                    r_c <= 4'd0;
                end
                OP_EMIT: begin
                    // hold the channel until the output register frees up
                    if (out_free) begin
                        r_c <= c_inc;
                    end
                end
                OP_CLEAR: begin
                    for (int i = 0; i < NC; i++) begin
                        r_sum[i] <= '0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_in_stall    = (uw.op != OP_WAIT);
    assign o_cfg_ready   = 1'b1;
    assign o_out_valid   = r_out_valid;
    assign o_out_channel = r_out_channel;
    assign o_out_sample  = r_out_sample;
    assign o_out_clipped = r_out_clipped;
    assign o_out_last    = r_out_last;

endmodule

// ===== rtl/agmm_check.sv =====
// Port-level checks on the mixer output stream, bound to the top level.
module agmm_check (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input logic [2:0]         o_out_channel,
    input logic signed [15:0] o_out_sample,
    input logic               o_out_clipped,
    input logic               o_out_last
);

    // Output empties on reset.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // A stalled output word holds.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_out_channel) && $stable(o_out_sample)
             && $stable(o_out_clipped) && $stable(o_out_last)))
        else $error("stalled output word changed");

    // Channels of a frame follow back to back in order.
    a_channel_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && !o_out_last) |=>
            (o_out_valid && o_out_channel == $past(o_out_channel) + 3'd1))
        else $error("frame channel sequence broken");

    // No input is taken while a frame word other than the last is on the output.
    a_frame_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_last) |-> o_in_stall)
        else $error("input taken during frame output");

endmodule

bind audio_gain_mixer_matrix agmm_check u_agmm_check (.*);
